// ----- rtl/core/drf_pkg.sv -----
// Shared types and constants for the dual-reader FIFO.
`default_nettype none

package drf_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 64;
	localparam int unsigned OP_W           = 3;
	localparam int unsigned ST_W           = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_READ_PROC  = 3'd1,
		OP_READ_STORE = 3'd2,
		OP_REMOVE     = 3'd3,
		OP_CLOSE      = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_CLOSED    = 3'd1,
		ST_FULL      = 3'd2,
		ST_NO_DATA   = 3'd3,
		ST_NO_REMOVE = 3'd4
	} status_t;

	typedef struct packed {
		status_t status;
		logic    rd_ok;
		logic    is_empty;
		logic    is_closed;
		logic    can_process;
		logic    can_store;
		logic    can_remove;
	} flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/drf_mem.sv -----
// Entry store: one write port, one read port, registered read data.
`default_nettype none

module drf_mem #(
	parameter int unsigned DEPTH      = drf_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = drf_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_WIDTH-1:0]    wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/drf_ctrl.sv -----
// Pointer control: writer, two readers, oldest entry, closed flag and status.
`default_nettype none

module drf_ctrl #(
	parameter int unsigned DEPTH      = drf_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = drf_pkg::DATA_WIDTH_DEF,
	localparam int unsigned AW        = $clog2(DEPTH),
	localparam int unsigned PW        = $clog2(2 * DEPTH),
	localparam int unsigned OCC_W     = $clog2(DEPTH + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic [drf_pkg::OP_W-1:0]   operation,
	input  wire logic [DATA_WIDTH-1:0]      payload,
	output logic                            mem_we,
	output logic      [AW-1:0]              mem_waddr,
	output logic      [DATA_WIDTH-1:0]      mem_wdata,
	output logic                            mem_re,
	output logic      [AW-1:0]              mem_raddr,
	output drf_pkg::flags_t                 flags,
	output logic      [OCC_W-1:0]           occupancy
);

	logic [PW-1:0] wr_q, old_q, proc_q, store_q;
	logic [PW-1:0] wr_n, old_n, proc_n, store_n;
	logic          closed_q, closed_n;
	logic [PW-1:0] occ_cur, occ_nxt;
	logic          removable;
	drf_pkg::status_t status;
	logic          rd_ok;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(2 * DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[PW]) begin
			d = d + (PW + 1)'(2 * DEPTH);
		end
		return d[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
		return s[AW-1:0];
	endfunction

	assign occ_cur   = ptr_dist(wr_q, old_q);
	assign removable = (occ_cur != '0) && (proc_q != old_q) && (store_q != old_q);

	always_comb begin
		wr_n      = wr_q;
		old_n     = old_q;
		proc_n    = proc_q;
		store_n   = store_q;
		closed_n  = closed_q;
		status    = drf_pkg::ST_OK;
		rd_ok     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = slot(proc_q);
		case (operation)
			drf_pkg::OP_INSERT: begin
				if (closed_q) begin
					status = drf_pkg::ST_CLOSED;
				end else if (occ_cur >= PW'(DEPTH)) begin
					status = drf_pkg::ST_FULL;
				end else begin
					mem_we = fire;
					wr_n   = ptr_next(wr_q);
				end
			end
			drf_pkg::OP_READ_PROC: begin
				if (proc_q == wr_q) begin
					status = drf_pkg::ST_NO_DATA;
				end else begin
					rd_ok  = 1'b1;
					mem_re = fire;
					proc_n = ptr_next(proc_q);
				end
			end
			drf_pkg::OP_READ_STORE: begin
				mem_raddr = slot(store_q);
				if (store_q == wr_q) begin
					status = drf_pkg::ST_NO_DATA;
				end else begin
					rd_ok   = 1'b1;
					mem_re  = fire;
					store_n = ptr_next(store_q);
				end
			end
			drf_pkg::OP_REMOVE: begin
				if (!removable) begin
					status = drf_pkg::ST_NO_REMOVE;
				end else begin
					old_n = ptr_next(old_q);
				end
			end
			drf_pkg::OP_CLOSE: begin
				closed_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = slot(wr_q);
	assign mem_wdata = payload;

	assign occ_nxt             = ptr_dist(wr_n, old_n);
	assign occupancy           = occ_nxt[OCC_W-1:0];
	assign flags.status        = status;
	assign flags.rd_ok         = rd_ok;
	assign flags.is_empty      = (occ_nxt == '0);
	assign flags.is_closed     = closed_n;
	assign flags.can_process   = (proc_n != wr_n);
	assign flags.can_store     = (store_n != wr_n);
	assign flags.can_remove    = (occ_nxt != '0) && (proc_n != old_n) && (store_n != old_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			old_q    <= '0;
			proc_q   <= '0;
			store_q  <= '0;
			closed_q <= 1'b0;
		end else if (fire) begin
			wr_q     <= wr_n;
			old_q    <= old_n;
			proc_q   <= proc_n;
			store_q  <= store_n;
			closed_q <= closed_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dual_reader_fifo_top.sv -----
// Top level of the dual-reader FIFO: stream ports, read stage and output register.
//
//   channel | dir | tdata fields (low bit up)                          | tuser
//   s_*     | in  | payload                                            | operation
//   m_*     | out | read_data, is_empty, is_closed, can_process,       | status
//           |     | can_store, can_remove, occupancy                   |
//
// One item per cycle while the output is taken; each result passes, after its item
// is accepted, through the read stage (the entry store read) and then the output
// register. Pointers and the closed flag change at the accepting edge.
// Reset clears all pointers and the closed flag; the entry store is not cleared.
// A stalled output holds the read stage, which then holds the input.
`default_nettype none

module dual_reader_fifo_top #(
	parameter int unsigned DEPTH      = drf_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = drf_pkg::DATA_WIDTH_DEF,
	localparam int unsigned OCC_W     = $clog2(DEPTH + 1),
	localparam int unsigned AW        = $clog2(DEPTH),
	localparam int unsigned IN_TW     = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_W     = DATA_WIDTH + 5 + OCC_W,
	localparam int unsigned OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [IN_TW-1:0]           s_tdata,   // payload
	input  wire logic [drf_pkg::OP_W-1:0]   s_tuser,   // operation
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [OUT_TW-1:0]          m_tdata,   // read_data, is_empty, is_closed,
	                                                   // can_process, can_store,
	                                                   // can_remove, occupancy
	output logic      [drf_pkg::ST_W-1:0]   m_tuser    // status
);

	logic                  fire;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	drf_pkg::flags_t       flags;
	logic [OCC_W-1:0]      occupancy;

	logic                  valid_s1;
	drf_pkg::flags_t       flags_s1;
	logic [OCC_W-1:0]      occ_s1;
	logic                  adv_s1;
	logic [DATA_WIDTH-1:0] read_data;

	logic                  m_valid_q;
	logic [OUT_TW-1:0]     m_data_q;
	logic [drf_pkg::ST_W-1:0] m_user_q;

	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign fire     = s_tvalid && s_tready;

	drf_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.operation  (s_tuser),
		.payload    (s_tdata[DATA_WIDTH-1:0]),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.flags      (flags),
		.occupancy  (occupancy)
	);

	drf_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_s1 <= flags;
			occ_s1   <= occupancy;
		end
	end

	assign read_data = flags_s1.rd_ok ? mem_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_data_q <= OUT_TW'({occ_s1, flags_s1.can_remove, flags_s1.can_store,
				flags_s1.can_process, flags_s1.is_closed, flags_s1.is_empty, read_data});
			m_user_q <= flags_s1.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

`default_nettype wire
